@@ hdl/sfl_pkg.sv @@
// ----------------------------------------------------------------------------
// Symbol floor lookup package
// Shared types, sizes and codes for the symbol floor lookup unit.
// ----------------------------------------------------------------------------
package sfl_pkg;

   localparam int MAX_SYMBOLS      = 1024;
   localparam int NAME_OFFSET_BITS = 16;
   localparam int ADDR_BITS        = 32;
   localparam int IDX_BITS         = $clog2(MAX_SYMBOLS);
   localparam int CNT_BITS         = $clog2(MAX_SYMBOLS + 1);
   localparam int CSR_INDEX_BITS   = 8;

   localparam logic [ADDR_BITS-1:0] LIMIT_RESET = 32'h0020_0000;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_LIMIT = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAW_MODE      = 8'd1;

   // Request functions.
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_LOADED  = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MATCH   = 2'd2;
   localparam logic [1:0] ST_NOMATCH = 2'd3;

   typedef struct packed {
      logic                  func;
      logic [ADDR_BITS-1:0]  address;
      logic [15:0]           name_ref;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [IDX_BITS-1:0]   entry_index;
      logic [ADDR_BITS-1:0]  base_address;
      logic [15:0]           name_offset;
      logic [ADDR_BITS-1:0]  displacement;
      logic                  within_limit;
   } rsp_type;

   // One stored symbol.
   typedef struct packed {
      logic [ADDR_BITS-1:0]        start;
      logic [NAME_OFFSET_BITS-1:0] name;
   } entry_type;

   // Write request into the symbol table.
   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
      entry_type           data;
   } tbl_write_type;

endpackage

@@ hdl/sfl_table.sv @@
// ----------------------------------------------------------------------------
// Symbol table memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module sfl_table (
   input  logic                         clock,
   input  sfl_pkg::tbl_write_type       wr,
   input  logic [sfl_pkg::IDX_BITS-1:0] rd_addr,
   output sfl_pkg::entry_type           rd_data
);
   import sfl_pkg::*;

   entry_type mem [MAX_SYMBOLS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sfl_search.sv @@
// ----------------------------------------------------------------------------
// Symbol floor search engine
// Appends loaded symbols and runs the predecessor binary search, one table
// probe per cycle, then reads back the final entry and forms the result.
// ----------------------------------------------------------------------------
module sfl_search (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  sfl_pkg::req_type              req,
   input  logic [sfl_pkg::ADDR_BITS-1:0] display_limit,
   input  logic                          raw_mode,
   output sfl_pkg::tbl_write_type        tbl_wr,
   output logic [sfl_pkg::IDX_BITS-1:0]  rd_addr,
   input  sfl_pkg::entry_type            rd_data,
   output logic                          rsp_valid,
   output sfl_pkg::rsp_type              rsp
);
   import sfl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_FINISH = 4'b0100,
      S_REPORT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  lo_ff, lo_in;
   logic [CNT_BITS-1:0]  hip1_ff, hip1_in;     // high bound plus one
   logic [IDX_BITS-1:0]  mid_ff, mid_in;
   logic [ADDR_BITS-1:0] query_ff, query_in;
   logic [IDX_BITS-1:0]  match_idx_ff, match_idx_in;
   logic [ADDR_BITS-1:0] base_ff, base_in;
   logic [NAME_OFFSET_BITS-1:0] name_ff, name_in;
   logic [ADDR_BITS-1:0] disp_ff, disp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [CNT_BITS-1:0]  lo_sel, hip1_sel;
   logic [CNT_BITS:0]    mid_sum;
   logic [IDX_BITS-1:0]  mid_next;
   logic [IDX_BITS-1:0]  final_idx;
   logic                 hit;
   logic                 more;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hip1_in      = hip1_ff;
      mid_in       = mid_ff;
      query_in     = query_ff;
      match_idx_in = match_idx_ff;
      base_in      = base_ff;
      name_in      = name_ff;
      disp_in      = disp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      tbl_wr       = '0;
      hit          = 1'b0;
      lo_sel       = lo_ff;
      hip1_sel     = hip1_ff;

      // Narrow the search window around the probe read last cycle.
      if (state_ff == S_SEARCH) begin
         if (query_ff < rd_data.start) begin
            hip1_sel = {1'b0, mid_ff};
         end else if (query_ff > rd_data.start) begin
            lo_sel = {1'b0, mid_ff} + CNT_BITS'(1);
         end else begin
            hip1_sel = {1'b0, mid_ff} + CNT_BITS'(1);
            hit      = 1'b1;
         end
      end else begin
         lo_sel   = '0;
         hip1_sel = count_ff;
      end

      mid_sum   = {1'b0, lo_sel} + {1'b0, hip1_sel} - (CNT_BITS + 1)'(1);
      mid_next  = mid_sum[IDX_BITS:1];
      final_idx = IDX_BITS'(hip1_sel - CNT_BITS'(1));
      more      = !hit && (lo_sel < hip1_sel);
      rd_addr   = mid_next;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               query_in = req.address;
               if (req.func == FUNC_LOAD) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  if (count_ff == CNT_BITS'(MAX_SYMBOLS)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     tbl_wr.en         = 1'b1;
                     tbl_wr.addr       = count_ff[IDX_BITS-1:0];
                     tbl_wr.data.start = req.address;
                     tbl_wr.data.name  = NAME_OFFSET_BITS'(req.name_ref);
                     count_in           = count_ff + CNT_BITS'(1);
                     rsp_in.status      = ST_LOADED;
                     rsp_in.entry_index = count_ff[IDX_BITS-1:0];
                  end
               end else if (raw_mode || count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in        = '0;
                  rsp_in.status = ST_NOMATCH;
               end else begin
                  lo_in    = lo_sel;
                  hip1_in  = hip1_sel;
                  mid_in   = mid_next;
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            lo_in   = lo_sel;
            hip1_in = hip1_sel;
            if (more) begin
               mid_in = mid_next;
            end else if (hip1_sel == '0) begin
               // The query lies below the first entry.
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.status = ST_NOMATCH;
               state_in      = S_IDLE;
            end else begin
               rd_addr      = final_idx;
               match_idx_in = final_idx;
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            base_in  = rd_data.start;
            name_in  = rd_data.name;
            disp_in  = query_ff - rd_data.start;
            state_in = S_REPORT;
         end
         S_REPORT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = ST_MATCH;
            rsp_in.entry_index  = match_idx_ff;
            rsp_in.base_address = base_ff;
            rsp_in.name_offset  = 16'(name_ff);
            rsp_in.displacement = disp_ff;
            rsp_in.within_limit = (disp_ff <= display_limit);
            state_in            = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hip1_ff      <= hip1_in;
      mid_ff       <= mid_in;
      query_ff     <= query_in;
      match_idx_ff <= match_idx_in;
      base_ff      <= base_in;
      name_ff      <= name_in;
      disp_ff      <= disp_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ hdl/symbol_floor_lookup_unit.sv @@
// ----------------------------------------------------------------------------
// Symbol floor lookup unit
// Loads symbols in ascending address order and finds the symbol at or below
// a query address by binary search over a single-port-read table memory.
// ----------------------------------------------------------------------------
// Load, raw mode or empty table: result strobe one cycle after the accepting edge.
// Lookup: one registered table read per probe, at most log2(1024)+1 = 11 probes. A match
// adds a final entry read (S_FINISH) and a result stage (S_REPORT) before the strobe;
// a query below the first entry strobes straight after its last probe.
// Busy drops as the strobe rises: no new request is accepted until the last one strobes.
// Reset (synchronous) empties the table and restores state and CSRs; no receiver stall.
module symbol_floor_lookup_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  sfl_pkg::req_type                   req_item,
   output logic                               rsp_strobe,
   output sfl_pkg::rsp_type                   rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sfl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                        csr_data
);
   import sfl_pkg::*;

   logic [ADDR_BITS-1:0] display_limit_ff, display_limit_in;
   logic                 raw_mode_ff, raw_mode_in;
   tbl_write_type        tbl_wr;
   logic [IDX_BITS-1:0]  rd_addr;
   entry_type            rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      display_limit_in = display_limit_ff;
      raw_mode_in      = raw_mode_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DISPLAY_LIMIT) begin
            display_limit_in = csr_data;
         end else if (csr_index == CSR_RAW_MODE) begin
            raw_mode_in = csr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_limit_ff <= LIMIT_RESET;
         raw_mode_ff      <= 1'b0;
      end else begin
         display_limit_ff <= display_limit_in;
         raw_mode_ff      <= raw_mode_in;
      end
   end

   sfl_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfl_search u_search (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req           (req_item),
      .display_limit (display_limit_ff),
      .raw_mode      (raw_mode_ff),
      .tbl_wr        (tbl_wr),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_strobe),
      .rsp           (rsp_item)
   );

   // A load transaction always answers in the next cycle.
   a_load_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.func == FUNC_LOAD) |=>
         (rsp_strobe && (rsp_item.status == ST_LOADED || rsp_item.status == ST_FULL)))
      else $error("load transaction did not answer in the next cycle");

   // In raw mode a lookup reports no match at once.
   a_raw_nomatch: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.func == FUNC_LOOKUP && raw_mode_ff) |=>
         (rsp_strobe && rsp_item.status == ST_NOMATCH))
      else $error("raw mode lookup did not report no match");

   // The table is only written while the engine is idle.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      tbl_wr.en |-> (!busy && start))
      else $error("table written outside an accepted load");

   // Only a match carries symbol data.
   a_nomatch_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != ST_MATCH) |->
         (rsp_item.base_address == '0 && rsp_item.displacement == '0 &&
          rsp_item.within_limit == 1'b0 && rsp_item.name_offset == '0))
      else $error("non-match result carries symbol data");

endmodule
